### design/ps2_mouse_device_emulator_core_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse emulator assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_DEVICE_EMULATOR_CORE_DEFINES_SVH
`define PS2_MOUSE_DEVICE_EMULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PS2ME_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define PS2ME_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PS2ME_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PS2ME_ASSERT_ALWAYS(label, expr)
`define PS2ME_ASSERT_SAME(label, ante, cons)
`define PS2ME_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/ps2me_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator package
// Payload types, reply descriptor, command codes and shared arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2me_pkg;

	localparam int ACC_W = 16;
	localparam int SUM_W = ((ACC_W > 12) ? ACC_W : 12) + 1;
	localparam int MAX_REPLY = 5;
	localparam int LEN_W = $clog2(MAX_REPLY + 1);
	localparam int IDX_W = $clog2(MAX_REPLY);
	localparam int QUEUE_DEPTH = 4;
	localparam int KNOCK_LEN = 6;

	typedef enum logic [1:0] {
		OP_MOTION = 2'd0,
		OP_CMD    = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [7:0] CMD_POLL     = 8'hEB;
	localparam logic [7:0] CMD_GET_ID   = 8'hF2;
	localparam logic [7:0] CMD_INFO     = 8'hE9;
	localparam logic [7:0] CMD_RESET    = 8'hFF;
	localparam logic [7:0] CMD_SET_RATE = 8'hF3;

	localparam logic [7:0] RSP_ACK    = 8'hFA;
	localparam logic [7:0] RSP_BAT_OK = 8'hAA;
	localparam logic [7:0] RSP_ZERO   = 8'h00;
	localparam logic [7:0] INFO_0     = 8'h60;
	localparam logic [7:0] INFO_1     = 8'h03;
	localparam logic [7:0] INFO_2     = 8'd200;
	localparam logic [7:0] ID_STD     = 8'd0;
	localparam logic [7:0] ID_WHEEL   = 8'd3;
	localparam logic [7:0] ID_EXT     = 8'd4;
	localparam logic [7:0] PKT_SYNC   = 8'h08;

	localparam logic [7:0] RATE_200 = 8'd200;
	localparam logic [7:0] RATE_100 = 8'd100;
	localparam logic [7:0] RATE_80  = 8'd80;

	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [11:0] move_x;
		logic signed [11:0] move_y;
		logic signed [7:0]  move_wheel;
		logic        [4:0]  button_bits;
		logic        [7:0]  command_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} reply_t;

	// One whole reply, bytes[0] goes out first.
	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [MAX_REPLY-1:0][7:0]       bytes;
	} reply_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Expected byte at each position of the two rate-setting knock sequences.
	function automatic logic [7:0] knock_byte(input logic ext, input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = CMD_SET_RATE;
			3'd1:    b = RATE_200;
			3'd2:    b = CMD_SET_RATE;
			3'd3:    b = ext ? RATE_200 : RATE_100;
			3'd4:    b = CMD_SET_RATE;
			3'd5:    b = RATE_80;
			default: b = RSP_ZERO;
		endcase
		return b;
	endfunction

	// Signed add that saturates to the accumulator range.
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [SUM_W-1:0] d
	);
		logic signed [SUM_W-1:0] s;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [ACC_W-1:0] r;
		hi = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
		lo = ~hi;
		s = {{(SUM_W-ACC_W){a[ACC_W-1]}}, a} + d;
		if (s > hi)
			r = hi[ACC_W-1:0];
		else if (s < lo)
			r = lo[ACC_W-1:0];
		else
			r = s[ACC_W-1:0];
		return r;
	endfunction

	// Symmetric clamp to +-lim, result fits in a byte.
	function automatic logic [7:0] clamp8(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] lim
	);
		logic signed [ACC_W-1:0] neg_lim;
		logic [7:0]              r;
		neg_lim = -lim;
		if (a > lim)
			r = lim[7:0];
		else if (a < neg_lim)
			r = neg_lim[7:0];
		else
			r = a[7:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### design/ps2me_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator front end
// Accepts items, updates accumulators, knock detectors and mode, and builds
// the complete reply of each item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2me_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	input  ps2me_pkg::item_t          item,
	output logic                      item_stall,
	input  ps2me_pkg::q_status_t      q_stat,
	output logic                      push,
	output ps2me_pkg::reply_desc_t    desc
);
	import ps2me_pkg::*;

	typedef enum logic [1:0] {
		MODE_STD   = 2'd0,
		MODE_WHEEL = 2'd1,
		MODE_EXT   = 2'd2
	} mode_t;

	localparam logic signed [ACC_W-1:0] LIM_XY = ACC_W'(127);
	localparam logic signed [ACC_W-1:0] LIM_EXT = ACC_W'(7);

	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_w_q;
	logic [4:0]              buttons_q;
	logic                    ready_q;
	mode_t                   mode_q;
	logic [2:0]              wheel_pos_q, ext_pos_q;

	logic signed [ACC_W-1:0] acc_x_d, acc_y_d, acc_w_d;
	logic [4:0]              buttons_d;
	logic                    ready_d;
	mode_t                   mode_d;
	logic [2:0]              wheel_pos_d, ext_pos_d;

	// Packet built from the current state.
	logic [7:0]              pkt_x, pkt_y, pkt_w;
	logic [3:0][7:0]         pkt_bytes;
	logic [LEN_W-1:0]        pkt_len;
	logic signed [ACC_W-1:0] pkt_acc_x, pkt_acc_y, pkt_acc_w;
	logic                    pkt_ready;

	logic                    accept;
	logic [7:0]              c;
	logic                    ext_match, wheel_match;

	assign item_stall = q_stat.full;
	assign accept = item_valid && !q_stat.full;
	assign c = item.command_byte;

	always_comb begin
		pkt_x = clamp8(acc_x_q, LIM_XY);
		pkt_y = clamp8(acc_y_q, LIM_XY);
		pkt_w = (mode_q == MODE_EXT) ? clamp8(acc_w_q, LIM_EXT) : clamp8(acc_w_q, LIM_XY);
		pkt_acc_x = acc_x_q - {{(ACC_W-8){pkt_x[7]}}, pkt_x};
		pkt_acc_y = acc_y_q - {{(ACC_W-8){pkt_y[7]}}, pkt_y};
		pkt_acc_w = acc_w_q;
		pkt_bytes[0] = PKT_SYNC | {2'b00, acc_y_q[ACC_W-1], acc_x_q[ACC_W-1], 1'b0,
			buttons_q[2:0]};
		pkt_bytes[1] = pkt_x;
		pkt_bytes[2] = pkt_y;
		pkt_bytes[3] = pkt_w;
		pkt_len = LEN_W'(3);
		if (mode_q == MODE_EXT) begin
			pkt_acc_w = acc_w_q - {{(ACC_W-8){pkt_w[7]}}, pkt_w};
			pkt_bytes[3] = {2'b00, buttons_q[4], buttons_q[3], pkt_w[3:0]};
			pkt_len = LEN_W'(4);
		end else begin
			// Side and extra buttons share byte0 in the standard and wheel formats.
			pkt_bytes[0] = pkt_bytes[0] | {5'b0, buttons_q[3], buttons_q[4], 1'b0};
			if (mode_q == MODE_WHEEL) begin
				pkt_acc_w = acc_w_q - {{(ACC_W-8){pkt_w[7]}}, pkt_w};
				pkt_len = LEN_W'(4);
			end
		end
		pkt_ready = ready_q;
		if (pkt_acc_x == '0 && pkt_acc_y == '0 && (mode_q == MODE_STD || pkt_acc_w == '0))
			pkt_ready = 1'b0;
	end

	always_comb begin
		acc_x_d = acc_x_q;
		acc_y_d = acc_y_q;
		acc_w_d = acc_w_q;
		buttons_d = buttons_q;
		ready_d = ready_q;
		mode_d = mode_q;
		wheel_pos_d = wheel_pos_q;
		ext_pos_d = ext_pos_q;
		push = 1'b0;
		desc = '0;
		ext_match = (ext_pos_q < 3'(KNOCK_LEN)) && (c == knock_byte(1'b1, ext_pos_q));
		wheel_match = (wheel_pos_q < 3'(KNOCK_LEN)) && (c == knock_byte(1'b0, wheel_pos_q));
		case (op_t'(item.opcode))
			OP_MOTION: begin
				acc_x_d = sat_add(acc_x_q, {{(SUM_W-12){item.move_x[11]}}, item.move_x});
				acc_y_d = sat_add(acc_y_q, {{(SUM_W-12){item.move_y[11]}}, item.move_y});
				acc_w_d = sat_add(acc_w_q,
					{{(SUM_W-8){item.move_wheel[7]}}, item.move_wheel});
				buttons_d = item.button_bits;
				ready_d = 1'b1;
			end
			OP_CMD: begin
				push = 1'b1;
				ext_pos_d = '0;
				if (ext_match && ext_pos_q == 3'(KNOCK_LEN - 1))
					mode_d = MODE_EXT;
				else if (ext_match)
					ext_pos_d = ext_pos_q + 3'd1;
				wheel_pos_d = '0;
				if (wheel_match && wheel_pos_q == 3'(KNOCK_LEN - 1))
					mode_d = MODE_WHEEL;
				else if (wheel_match)
					wheel_pos_d = wheel_pos_q + 3'd1;
				desc.bytes[0] = RSP_ACK;
				desc.len = LEN_W'(1);
				case (c)
					CMD_POLL: begin
						desc.bytes[4:1] = pkt_bytes;
						desc.len = pkt_len + LEN_W'(1);
						acc_x_d = pkt_acc_x;
						acc_y_d = pkt_acc_y;
						acc_w_d = pkt_acc_w;
						ready_d = pkt_ready;
					end
					CMD_GET_ID: begin
						// The ID reflects the mode before this byte.
						case (mode_q)
							MODE_WHEEL: desc.bytes[1] = ID_WHEEL;
							MODE_EXT:   desc.bytes[1] = ID_EXT;
							default:    desc.bytes[1] = ID_STD;
						endcase
						desc.len = LEN_W'(2);
					end
					CMD_INFO: begin
						desc.bytes[1] = INFO_0;
						desc.bytes[2] = INFO_1;
						desc.bytes[3] = INFO_2;
						desc.len = LEN_W'(4);
					end
					CMD_RESET: begin
						wheel_pos_d = '0;
						ext_pos_d = '0;
						mode_d = MODE_STD;
						desc.bytes[1] = RSP_BAT_OK;
						desc.bytes[2] = RSP_ZERO;
						desc.len = LEN_W'(3);
					end
					default: ;
				endcase
			end
			OP_READ: begin
				if (ready_q) begin
					push = 1'b1;
					desc.bytes[3:0] = pkt_bytes;
					desc.len = pkt_len;
					acc_x_d = pkt_acc_x;
					acc_y_d = pkt_acc_y;
					acc_w_d = pkt_acc_w;
					ready_d = pkt_ready;
				end
			end
			default: ;
		endcase
		if (!accept)
			push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_w_q <= '0;
			buttons_q <= '0;
			ready_q <= 1'b0;
			mode_q <= MODE_STD;
			wheel_pos_q <= '0;
			ext_pos_q <= '0;
		end else if (accept) begin
			acc_x_q <= acc_x_d;
			acc_y_q <= acc_y_d;
			acc_w_q <= acc_w_d;
			buttons_q <= buttons_d;
			ready_q <= ready_d;
			mode_q <= mode_d;
			wheel_pos_q <= wheel_pos_d;
			ext_pos_q <= ext_pos_d;
		end
	end

endmodule

`default_nettype wire

### design/ps2me_queue.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator reply queue
// Small FIFO of whole reply descriptors between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2me_queue (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  ps2me_pkg::reply_desc_t    wr_desc,
	input  wire                       pop,
	output ps2me_pkg::reply_desc_t    head,
	output ps2me_pkg::q_status_t      q_stat
);
	import ps2me_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	reply_desc_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head = entry_q[rd_ptr_q];
	assign q_stat.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### design/ps2me_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator back end
// Walks the head reply byte by byte into the registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2me_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ps2me_pkg::reply_desc_t    head,
	input  ps2me_pkg::q_status_t      q_stat,
	output logic                      pop,
	output logic                      reply_valid,
	input  wire                       reply_stall,
	output ps2me_pkg::reply_t         reply
);
	import ps2me_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	reply_t           reply_q;
	logic             load;
	logic             at_last;

	assign reply_valid = valid_q;
	assign reply = reply_q;
	// With a reply queued, the output word refills in the same cycle it is taken.
	assign load = !q_stat.empty && (!valid_q || !reply_stall);
	assign at_last = (LEN_W'(idx_q) + LEN_W'(1)) == head.len;
	assign pop = load && at_last;

	always_ff @(posedge clk) begin
		if (load) begin
			reply_q.data_byte <= head.bytes[idx_q];
			reply_q.last_byte <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end else if (!reply_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### design/ps2_mouse_device_emulator_core.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device emulator core
// Device side of a PS/2 mouse with wheel and five buttons.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries motion reports, host command bytes and read
// requests. The reply channel returns the bytes owed to the host one word
// at a time, last_byte marking the final byte of one item's reply.
// An item is taken in the cycle it is offered as long as the reply queue
// (four whole replies) has room; its reply is registered in the queue and
// then in the output register. Items that produce no reply queue nothing.
// Throughput is set by the reply serializer: one byte per cycle unless the
// receiver stalls; a reply is 1 to 5 bytes (ACK plus packet at most).
// While the receiver stalls, the current word holds, the queue fills and
// the item channel then stalls until a reply drains.
// Reset clears the accumulators, buttons, ready flag, mode and both knock
// detectors, and empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_device_emulator_core_defines.svh"

module ps2_mouse_device_emulator_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  ps2me_pkg::item_t    item,
	output logic                reply_valid,
	input  wire                 reply_stall,
	output ps2me_pkg::reply_t   reply
);
	import ps2me_pkg::*;

	q_status_t   q_stat;
	reply_desc_t wr_desc;
	reply_desc_t head;
	logic        push;
	logic        pop;

	ps2me_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_stat     (q_stat),
		.push       (push),
		.desc       (wr_desc)
	);

	ps2me_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	ps2me_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply)
	);

	`PS2ME_ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty))
	`PS2ME_ASSERT_SAME(a_no_push_full, push, !q_stat.full)
	`PS2ME_ASSERT_SAME(a_no_pop_empty, pop, !q_stat.empty)
	`PS2ME_ASSERT_NEXT(a_reply_continues, reply_valid && !reply_stall && !reply.last_byte, reply_valid)

endmodule

`default_nettype wire

### test/ps2me_reply_checker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator reply checker
// Watches the item and reply channels, keeps its own copy of the mouse state,
// works out the reply bytes every accepted item owes and compares each
// delivered word with the oldest byte still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ps2me_reply_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  wire                 item_stall,
	input  ps2me_pkg::item_t    item,
	input  wire                 reply_valid,
	input  wire                 reply_stall,
	input  ps2me_pkg::reply_t   reply,
	output int                  fail_count,
	output int                  bytes_owed
);

	import ps2me_pkg::*;

	typedef enum logic [1:0] {
		MODE_STD   = 2'd0,
		MODE_WHEEL = 2'd1,
		MODE_EXT   = 2'd2
	} report_mode_t;

	// Index 0 is the first byte the host has to send.
	localparam logic [KNOCK_LEN-1:0][7:0] WHEEL_KNOCK = {RATE_80, CMD_SET_RATE, RATE_100,
		CMD_SET_RATE, RATE_200, CMD_SET_RATE};
	localparam logic [KNOCK_LEN-1:0][7:0] EXT_KNOCK = {RATE_80, CMD_SET_RATE, RATE_200,
		CMD_SET_RATE, RATE_200, CMD_SET_RATE};

	logic signed [ACC_W-1:0] sum_x;
	logic signed [ACC_W-1:0] sum_y;
	logic signed [ACC_W-1:0] sum_wheel;
	logic [4:0]              buttons_held;
	logic                    motion_ready;
	report_mode_t            mode;
	logic [2:0]              wheel_pos;
	logic [2:0]              ext_pos;
	logic [7:0]              reply_bytes[$];
	reply_t                  owed_bytes[$];

	function automatic logic signed [ACC_W-1:0] add_saturated(
		input logic signed [ACC_W-1:0] acc,
		input int                      delta
	);
		int ceiling;
		int sum;
		ceiling = (1 <<< (ACC_W - 1)) - 1;
		sum = int'(acc) + delta;
		if (sum > ceiling)
			sum = ceiling;
		else if (sum < -ceiling - 1)
			sum = -ceiling - 1;
		return ACC_W'(sum);
	endfunction

	function automatic int limit_mag(input int v, input int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic [2:0] next_knock_pos(
		input logic [2:0]                  pos,
		input logic [KNOCK_LEN-1:0][7:0]   seq,
		input logic [7:0]                  c
	);
		if (pos < 3'(KNOCK_LEN - 1) && c == seq[pos])
			return pos + 3'd1;
		return 3'd0;
	endfunction

	// Sign bits come from the totals before the sent amount is taken off.
	function automatic void append_packet();
		int         x_sent;
		int         y_sent;
		int         w_sent;
		logic [7:0] head;
		logic [7:0] tail;
		x_sent = limit_mag(int'(sum_x), 127);
		y_sent = limit_mag(int'(sum_y), 127);
		w_sent = 0;
		tail = 8'h00;
		head = PKT_SYNC | {2'b00, sum_y[ACC_W-1], sum_x[ACC_W-1], 4'b0000} |
			{5'b00000, buttons_held[2:0]};
		sum_x = sum_x - ACC_W'(x_sent);
		sum_y = sum_y - ACC_W'(y_sent);
		if (mode == MODE_EXT) begin
			w_sent = limit_mag(int'(sum_wheel), 7);
			tail = {2'b00, buttons_held[4:3], w_sent[3:0]};
		end else begin
			// Side and extra buttons fold into the first byte.
			head = head | {5'b00000, buttons_held[3], buttons_held[4], 1'b0};
			if (mode == MODE_WHEEL) begin
				w_sent = limit_mag(int'(sum_wheel), 127);
				tail = w_sent[7:0];
			end
		end
		sum_wheel = sum_wheel - ACC_W'(w_sent);
		reply_bytes.push_back(head);
		reply_bytes.push_back(x_sent[7:0]);
		reply_bytes.push_back(y_sent[7:0]);
		if (mode != MODE_STD)
			reply_bytes.push_back(tail);
		if (sum_x == 0 && sum_y == 0 && (mode == MODE_STD || sum_wheel == 0))
			motion_ready = 1'b0;
	endfunction

	function automatic void predict_mouse_reply(input item_t w);
		logic ext_hit;
		logic wheel_hit;
		reply_bytes.delete();
		case (w.opcode)
			OP_MOTION: begin
				sum_x = add_saturated(sum_x, int'(w.move_x));
				sum_y = add_saturated(sum_y, int'(w.move_y));
				sum_wheel = add_saturated(sum_wheel, int'(w.move_wheel));
				buttons_held = w.button_bits;
				motion_ready = 1'b1;
			end
			OP_CMD: begin
				ext_hit = (ext_pos == 3'(KNOCK_LEN - 1)) &&
					(w.command_byte == EXT_KNOCK[KNOCK_LEN-1]);
				wheel_hit = (wheel_pos == 3'(KNOCK_LEN - 1)) &&
					(w.command_byte == WHEEL_KNOCK[KNOCK_LEN-1]);
				ext_pos = next_knock_pos(ext_pos, EXT_KNOCK, w.command_byte);
				wheel_pos = next_knock_pos(wheel_pos, WHEEL_KNOCK, w.command_byte);
				if (ext_hit)
					mode = MODE_EXT;
				if (wheel_hit)
					mode = MODE_WHEEL;
				reply_bytes.push_back(RSP_ACK);
				case (w.command_byte)
					CMD_POLL: begin
						append_packet();
					end
					CMD_GET_ID: begin
						if (mode == MODE_WHEEL)
							reply_bytes.push_back(ID_WHEEL);
						else if (mode == MODE_EXT)
							reply_bytes.push_back(ID_EXT);
						else
							reply_bytes.push_back(ID_STD);
					end
					CMD_INFO: begin
						reply_bytes.push_back(INFO_0);
						reply_bytes.push_back(INFO_1);
						reply_bytes.push_back(INFO_2);
					end
					CMD_RESET: begin
						wheel_pos = 3'd0;
						ext_pos = 3'd0;
						mode = MODE_STD;
						reply_bytes.push_back(RSP_BAT_OK);
						reply_bytes.push_back(RSP_ZERO);
					end
					default: begin
					end
				endcase
			end
			OP_READ: begin
				if (motion_ready)
					append_packet();
			end
			default: begin
			end
		endcase
		foreach (reply_bytes[k])
			owed_bytes.push_back('{data_byte: reply_bytes[k],
				last_byte: (k == reply_bytes.size() - 1)});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x = '0;
			sum_y = '0;
			sum_wheel = '0;
			buttons_held = '0;
			motion_ready = 1'b0;
			mode = MODE_STD;
			wheel_pos = 3'd0;
			ext_pos = 3'd0;
			owed_bytes.delete();
			fail_count = 0;
			bytes_owed = 0;
		end else begin
			// A word delivered now always belongs to an item taken earlier.
			if (reply_valid && !reply_stall) begin
				if (owed_bytes.size() == 0) begin
					$error("data_byte: expected none, actual %02h", reply.data_byte);
					fail_count = fail_count + 1;
				end else begin
					if (reply.data_byte !== owed_bytes[0].data_byte) begin
						$error("data_byte: expected %02h, actual %02h",
							owed_bytes[0].data_byte, reply.data_byte);
						fail_count = fail_count + 1;
					end
					if (reply.last_byte !== owed_bytes[0].last_byte) begin
						$error("last_byte: expected %0b, actual %0b",
							owed_bytes[0].last_byte, reply.last_byte);
						fail_count = fail_count + 1;
					end
					void'(owed_bytes.pop_front());
				end
			end
			if (item_valid && !item_stall)
				predict_mouse_reply(item);
			bytes_owed = owed_bytes.size();
		end
	end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// PS/2 mouse emulator testbench
// Drives motion reports, host commands, knock sequences and read requests
// into the core with bursty traffic and a stalling host side, and reports
// the verdict from the reply checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import ps2me_pkg::*;

	localparam int RANDOM_WORDS = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic   clk;
	logic   arst_n;
	logic   item_valid;
	logic   item_stall;
	item_t  item;
	logic   reply_valid;
	logic   reply_stall;
	reply_t reply;
	int     fail_count;
	int     bytes_owed;

	logic   hold_req = 1'b0;
	logic   draining = 1'b0;
	int     burst_left = 0;
	int     words_sent = 0;

	ps2_mouse_device_emulator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply)
	);

	ps2me_reply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply),
		.fail_count  (fail_count),
		.bytes_owed  (bytes_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fields that the opcode does not use still carry random bits.
	function automatic item_t random_word();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic item_t motion_word(
		input logic signed [11:0] dx,
		input logic signed [11:0] dy,
		input logic signed [7:0]  dw,
		input logic [4:0]         btn
	);
		item_t w;
		w = random_word();
		w.opcode = OP_MOTION;
		w.move_x = dx;
		w.move_y = dy;
		w.move_wheel = dw;
		w.button_bits = btn;
		return w;
	endfunction

	function automatic item_t command_word(input logic [7:0] c);
		item_t w;
		w = random_word();
		w.opcode = OP_CMD;
		w.command_byte = c;
		return w;
	endfunction

	function automatic item_t read_word();
		item_t w;
		w = random_word();
		w.opcode = OP_READ;
		return w;
	endfunction

	// Called and left at a falling edge; bursts of words with random gaps.
	task automatic send_word(input item_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left = burst_left - 1;
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (w.opcode != OP_NONE)
			words_sent = words_sent + 1;
		@(negedge clk);
	endtask

	task automatic send_knock(input logic ext, input logic spoil);
		int         bad_at;
		logic [7:0] c;
		bad_at = spoil ? $urandom_range(0, KNOCK_LEN - 1) : KNOCK_LEN;
		for (int i = 0; i < KNOCK_LEN; i++) begin
			case (i)
				1:       c = RATE_200;
				3:       c = ext ? RATE_200 : RATE_100;
				5:       c = RATE_80;
				default: c = CMD_SET_RATE;
			endcase
			if (i == bad_at)
				c = 8'($urandom);
			send_word(command_word(c));
		end
	endtask

	// Host side stall pattern, with one long hold-off on request.
	initial begin
		int   pattern;
		int   span;
		logic hold_done;
		reply_stall = 1'b0;
		pattern = 0;
		span = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				reply_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				reply_stall <= 1'b0;
			end else begin
				if (span == 0) begin
					pattern = $urandom_range(0, 3);
					span = $urandom_range(8, 60);
				end
				span = span - 1;
				if (draining || pattern == 0)
					reply_stall <= 1'b0;
				else if (pattern == 1)
					reply_stall <= ($urandom_range(0, 4) == 0);
				else if (pattern == 2)
					reply_stall <= ($urandom_range(0, 2) != 0);
				else
					reply_stall <= ~reply_stall;
			end
		end
	end

	// Ends the run when no word moves on either channel for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (reply_valid && !reply_stall))
				idle = 0;
			else
				idle = idle + 1;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int         words_before;
		int         d;
		logic       neg;
		logic       pressure_done;
		logic [4:0] btn;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		pressure_done = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle replies, empty packets, then each report mode.
		send_word(command_word(CMD_RESET));
		send_word(random_word() | item_t'({2'b11, {($bits(item_t) - 2){1'b0}}}));
		send_word(read_word());
		send_word(command_word(CMD_GET_ID));
		send_word(command_word(CMD_INFO));
		send_word(command_word(CMD_POLL));
		send_word(motion_word(12'(2047), 12'(-2048), 8'(127), 5'h1F));
		send_word(read_word());
		send_knock(1'b0, 1'b0);
		send_word(command_word(CMD_GET_ID));
		send_word(motion_word(12'(-2048), 12'(2047), 8'(-128), 5'h0A));
		send_word(read_word());
		send_knock(1'b1, 1'b0);
		send_word(command_word(CMD_GET_ID));
		send_word(read_word());
		send_word(command_word(CMD_POLL));

		words_before = words_sent;
		while (words_sent - words_before < RANDOM_WORDS) begin
			btn = 5'($urandom);
			case ($urandom_range(0, 19))
				0, 1: begin
					send_knock(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
				end
				2, 3, 4, 5, 6, 7: begin
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(0, 1) == 0) begin
							send_word(motion_word(12'($urandom), 12'($urandom),
								8'($urandom), 5'($urandom)));
						end else begin
							d = int'($urandom_range(0, 30)) - 15;
							send_word(motion_word(12'(d), 12'(-d), 8'(d / 2),
								5'($urandom)));
						end
					end
				end
				8, 9, 10, 11, 12, 13: begin
					repeat ($urandom_range(1, 3))
						send_word(read_word());
				end
				14, 15: begin
					case ($urandom_range(0, 3))
						0:       send_word(command_word(CMD_POLL));
						1:       send_word(command_word(CMD_GET_ID));
						2:       send_word(command_word(CMD_INFO));
						default: send_word(command_word(CMD_SET_RATE));
					endcase
				end
				16: begin
					send_word(command_word(8'($urandom)));
				end
				17: begin
					send_word(random_word() | item_t'({2'b11, {($bits(item_t) - 2){1'b0}}}));
				end
				18: begin
					send_word(command_word(CMD_RESET));
				end
				default: begin
					// Long same-sign run that drives the totals into saturation.
					neg = 1'($urandom_range(0, 1));
					repeat ($urandom_range(17, 20))
						send_word(motion_word(neg ? 12'(-2048) : 12'(2047),
							neg ? 12'(2047) : 12'(-2048),
							neg ? 8'(-128) : 8'(127), btn));
				end
			endcase
			if (!pressure_done && words_sent - words_before > 60) begin
				pressure_done = 1'b1;
				hold_req = 1'b1;
				repeat (8)
					send_word(command_word(CMD_GET_ID));
			end
		end

		item_valid <= 1'b0;
		draining = 1'b1;
		while (bytes_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
